// ===== sv/delta_nybble_packet_encoder_top_assert.svh =====
// Assertion macros shared by the checker of the delta nybble packet encoder.
// Each macro names its label, antecedent, consequent and message.
`ifndef DELTA_NYBBLE_PACKET_ENCODER_TOP_ASSERT_SVH
`define DELTA_NYBBLE_PACKET_ENCODER_TOP_ASSERT_SVH

// Check in the same cycle, ignored while reset is applied.
`define DNPE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Check in the following cycle, ignored while reset is applied.
`define DNPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Check in the following cycle, reset included.
`define DNPE_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/dnpe_pkg.sv =====
package dnpe_pkg;

    // Coding command handed from the front to the back
    typedef struct packed {
        logic        flush;  // emit the open packet before coding
        logic [1:0]  cnt;    // number of nybbles to write, 1 to 3
        logic [11:0] nyb;    // nybbles, first one in the top bits
    } t_cmd;

    // One result item: a packet byte and its place
    typedef struct packed {
        logic [7:0] data;
        logic [4:0] index;
        logic       last;
    } t_res;

    localparam logic [3:0] NYB_ESC       = 4'hF;
    localparam logic [7:0] PAD_BYTE      = 8'hFF;
    localparam logic [7:0] DELTA_POS_MAX = 8'd7;
    localparam logic [7:0] DELTA_NEG_MIN = 8'd249;

    localparam int CQ_DEPTH = 2;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_CW    = 3;

endpackage

// ===== sv/dnpe_fifo.sv =====
module dnpe_fifo import dnpe_pkg::*; #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [W-1:0]                 i_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output logic                         o_empty,
    output logic [W-1:0]                 o_data,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          push_ok;
    logic          pop_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    // store an incoming item
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + AW'(1);
            end
            if (pop_ok) begin
                r_rp <= r_rp + AW'(1);
            end
            r_cnt <= r_cnt + CW'(push_ok) - CW'(pop_ok);
        end
    end

endmodule

// ===== sv/dnpe_front.sv =====
module dnpe_front import dnpe_pkg::*; #(
    parameter int PACKET_BYTES = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_sample,
    output logic       o_full,
    input  logic       i_q_full,
    output logic       o_q_push,
    output t_cmd       o_cmd
);

    localparam int DN = 2 * (PACKET_BYTES - 1);
    localparam int FW = $clog2(DN + 1);

    logic [FW-1:0] r_fill;
    logic [FW-1:0] n_fill;
    logic [7:0]    r_prev;
    logic [7:0]    delta;
    logic          is_short;
    logic [1:0]    need;
    logic [FW-1:0] room;
    logic          flush;
    logic          raw;
    logic          accept;

    assign o_full   = i_q_full;
    assign accept   = i_push && !i_q_full;
    assign o_q_push = accept;

    // classify the sample against the mirrored packet fill
    always_comb begin
        delta    = i_sample - r_prev;
        is_short = (delta <= DELTA_POS_MAX) || (delta >= DELTA_NEG_MIN);
        need     = is_short ? 2'd1 : 2'd3;
        room     = FW'(DN) - r_fill;
        flush    = FW'(need) > room;
        raw      = flush || (r_fill == '0);

        o_cmd.flush = flush;
        if (raw) begin
            o_cmd.cnt = 2'd2;
            o_cmd.nyb = {i_sample, 4'h0};
        end else if (delta <= DELTA_POS_MAX) begin
            o_cmd.cnt = 2'd1;
            o_cmd.nyb = {delta[3:0], 8'h00};
        end else if (is_short) begin
            o_cmd.cnt = 2'd1;
            o_cmd.nyb = {delta[3:0] - 4'd1, 8'h00};
        end else begin
            o_cmd.cnt = 2'd3;
            o_cmd.nyb = {NYB_ESC, delta};
        end

        n_fill = raw ? FW'(2) : r_fill + FW'(o_cmd.cnt);
    end

    // track fill and previous sample per accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_prev <= '0;
        end else if (accept) begin
            r_fill <= n_fill;
            r_prev <= i_sample;
        end
    end

endmodule

// ===== sv/dnpe_back.sv =====
module dnpe_back import dnpe_pkg::*; #(
    parameter int PACKET_BYTES = 20
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_empty,
    input  t_cmd             i_cmd,
    output logic             o_cmd_pop,
    input  logic [OQ_CW-1:0] i_out_count,
    output logic             o_out_push,
    output t_res             o_out
);

    localparam int DB = PACKET_BYTES - 1;
    localparam int DN = 2 * DB;
    localparam int FW = $clog2(DN + 1);
    localparam int IW = $clog2(PACKET_BYTES);
    localparam int AW = (DB > 1) ? $clog2(DB) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EMIT  = 2'd1;
    localparam logic [1:0] S_FIN   = 2'd2;
    localparam logic [1:0] S_WRITE = 2'd3;

    logic [1:0]    r_state;
    t_cmd          r_cmd;
    logic [1:0]    r_left;
    logic [FW-1:0] r_fill;
    logic [7:0]    r_seq;
    logic [3:0]    r_part;
    logic [IW-1:0] r_ridx;
    logic [IW-1:0] r_pidx;
    logic          r_rd_vld;
    logic [7:0]    r_rd;
    logic [7:0]    r_mem [DB];

    logic          issue;
    logic          issue_last;
    logic          wr_en;
    logic [3:0]    cur_nyb;
    logic [7:0]    pidx_ext;
    logic [7:0]    fbyte_ext;

    assign o_cmd_pop  = (r_state == S_IDLE) && !i_cmd_empty;
    assign issue      = (r_state == S_EMIT) &&
                        (({1'b0, i_out_count} + (OQ_CW+1)'(r_rd_vld)) <
                         (OQ_CW+1)'(OQ_DEPTH));
    assign issue_last = (r_ridx == IW'(DB));
    assign wr_en      = (r_state == S_WRITE);
    assign cur_nyb    = r_cmd.nyb[11:8];
    assign pidx_ext   = 8'(r_pidx);
    assign fbyte_ext  = 8'(r_fill[FW-1:1]);

    // form the outgoing byte, padding nybbles never written
    always_comb begin
        o_out_push  = r_rd_vld;
        o_out.index = 5'(r_pidx);
        o_out.last  = (r_pidx == IW'(DB));
        if (o_out.last) begin
            o_out.data = r_seq;
        end else if (pidx_ext < fbyte_ext) begin
            o_out.data = r_rd;
        end else if ((pidx_ext == fbyte_ext) && r_fill[0]) begin
            o_out.data = {r_part, NYB_ESC};
        end else begin
            o_out.data = PAD_BYTE;
        end
    end

    // packet store: complete bytes in, registered read out
    always_ff @(posedge i_clk) begin
        if (wr_en && r_fill[0]) begin
            r_mem[r_fill[AW:1]] <= {r_part, cur_nyb};
        end
        if (issue && !issue_last) begin
            r_rd <= r_mem[r_ridx[AW-1:0]];
        end
    end

    // hold the high nybble of the open byte and the command payload
    always_ff @(posedge i_clk) begin
        if (wr_en && !r_fill[0]) begin
            r_part <= cur_nyb;
        end
        if (issue) begin
            r_pidx <= r_ridx;
        end
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end else if (wr_en) begin
            r_cmd.nyb <= {r_cmd.nyb[7:0], 4'h0};
        end
    end

    // sequence commands: emit on flush, then write nybbles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_left   <= '0;
            r_fill   <= '0;
            r_seq    <= '0;
            r_ridx   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= issue;
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_left  <= i_cmd.cnt;
                        r_ridx  <= '0;
                        r_state <= i_cmd.flush ? S_EMIT : S_WRITE;
                    end
                end
                S_EMIT: begin
                    if (issue) begin
                        r_ridx <= r_ridx + IW'(1);
                        if (issue_last) begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_FIN: begin
                    r_fill  <= '0;
                    r_seq   <= r_seq + 8'd1;
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_fill <= r_fill + FW'(1);
                    r_left <= r_left - 2'd1;
                    if (r_left == 2'd1) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== sv/delta_nybble_packet_encoder_top.sv =====
// Delta nybble packet encoder. Push 8-bit samples in; pop packet bytes out,
// PACKET_BYTES per packet, data bytes first and a wrapping sequence number
// last (o_last_byte high). A packet leaves only when a later sample no
// longer fits, and that sample opens the next packet. For each sample the
// back end first takes its command and then writes its nybbles, one nybble
// per cycle, into the packet store. A sample that closes a packet first
// streams the packet out, one byte per cycle while the result queue has
// room, then steps the sequence number. A two-entry command queue lets
// samples be taken while the back end is busy, and a four-entry result
// queue holds bytes not yet popped. No clearing pass is needed after reset.
module delta_nybble_packet_encoder_top import dnpe_pkg::*; #(
    parameter int PACKET_BYTES = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_sample,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_packet_byte,
    output logic [4:0] o_byte_index,
    output logic       o_last_byte
);

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_res);

    t_cmd             fe_cmd;
    logic             fe_push;
    logic             cq_full;
    logic             cq_empty;
    logic [CMD_W-1:0] cq_rdata;
    t_cmd             be_cmd;
    logic             be_pop;
    logic             be_push;
    t_res             be_res;
    logic [OQ_CW-1:0] oq_count;
    logic [RES_W-1:0] oq_rdata;
    t_res             oq_res;

    assign be_cmd        = cq_rdata;
    assign oq_res        = oq_rdata;
    assign o_packet_byte = oq_res.data;
    assign o_byte_index  = oq_res.index;
    assign o_last_byte   = oq_res.last;

    dnpe_front #(.PACKET_BYTES(PACKET_BYTES)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_sample (i_sample),
        .o_full   (full),
        .i_q_full (cq_full),
        .o_q_push (fe_push),
        .o_cmd    (fe_cmd)
    );

    dnpe_fifo #(.W(CMD_W), .DEPTH(CQ_DEPTH)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_data  (fe_cmd),
        .o_full  (cq_full),
        .i_pop   (be_pop),
        .o_empty (cq_empty),
        .o_data  (cq_rdata),
        .o_count ()
    );

    dnpe_back #(.PACKET_BYTES(PACKET_BYTES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cq_empty),
        .i_cmd       (be_cmd),
        .o_cmd_pop   (be_pop),
        .i_out_count (oq_count),
        .o_out_push  (be_push),
        .o_out       (be_res)
    );

    dnpe_fifo #(.W(RES_W), .DEPTH(OQ_DEPTH)) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (be_push),
        .i_data  (be_res),
        .o_full  (),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (oq_rdata),
        .o_count (oq_count)
    );

endmodule

// ===== sv/dnpe_checker.sv =====
`include "delta_nybble_packet_encoder_top_assert.svh"

module dnpe_checker #(
    parameter int PACKET_BYTES = 20
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       pop,
    input logic       empty,
    input logic [7:0] o_packet_byte,
    input logic [4:0] o_byte_index,
    input logic       o_last_byte
);

    localparam logic [4:0] LAST_IDX = 5'(PACKET_BYTES - 1);

    // no result may be shown right after reset
    `DNPE_ASSERT_RST(a_empty_after_rst, !i_rst_n, empty, "result shown after reset")

    // a waiting result holds until popped
    `DNPE_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(o_packet_byte), "result dropped or changed")

    // the sequence byte sits at the end of the packet
    `DNPE_ASSERT_NOW(a_last_idx, !empty && o_last_byte, o_byte_index == LAST_IDX, "sequence byte misplaced")

    // data bytes of a packet come out in order
    `DNPE_ASSERT_NEXT(a_idx_step, pop && !empty && !o_last_byte, empty || (o_byte_index == 5'($past(o_byte_index) + 5'd1)), "byte index skipped")

endmodule

bind delta_nybble_packet_encoder_top dnpe_checker #(.PACKET_BYTES(PACKET_BYTES)) u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .pop           (pop),
    .empty         (empty),
    .o_packet_byte (o_packet_byte),
    .o_byte_index  (o_byte_index),
    .o_last_byte   (o_last_byte)
);
